// File: rtl/core/paired_end_distance_histogram_top_defines.svh
// assertion helpers used by the histogram top level
`ifndef PAIRED_END_DISTANCE_HISTOGRAM_TOP_DEFINES_SVH
`define PAIRED_END_DISTANCE_HISTOGRAM_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PEDH_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PEDH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pedh_pkg.sv
`default_nettype none

package pedh_pkg;

  localparam int NUM_BINS    = 4096;
  localparam int BIN_AW      = $clog2(NUM_BINS);
  localparam int IDX_W       = 12;
  localparam int CNT_W       = 32;
  localparam int DIST_W      = 32;
  localparam int BSIZE_W     = 31;
  localparam int PROD_W      = IDX_W + BSIZE_W;
  localparam int SPAN_W      = PROD_W + 1;
  localparam int BND_W       = SPAN_W + 1;
  localparam int STEP_W      = $clog2(IDX_W);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int IN_TDATA_W  = 136;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 3;
  localparam int APB_AW      = 4;

  localparam logic [7:0] PAIR_ENDS   = 8'd2;
  localparam logic [7:0] UNIQUE_HITS = 8'd1;

  localparam logic signed [BND_W-1:0] SAT_HI =
    $signed({{(BND_W-DIST_W+1){1'b0}}, {(DIST_W-1){1'b1}}});
  localparam logic signed [BND_W-1:0] SAT_LO =
    $signed({{(BND_W-DIST_W+1){1'b1}}, {(DIST_W-1){1'b0}}});

  typedef enum logic [1:0] {
    REG_MIN_DIST = 2'd0,
    REG_MAX_DIST = 2'd1,
    REG_BIN_SIZE = 2'd2
  } reg_e;

  typedef enum logic [0:0] {
    OP_INSERT  = 1'b0,
    OP_READOUT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_COUNTED      = 3'd0,
    ST_NOT_PAIRED   = 3'd1,
    ST_NOT_UNIQUE   = 3'd2,
    ST_MISMATCH     = 3'd3,
    ST_OUT_OF_RANGE = 3'd4,
    ST_READOUT      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_UPD,
    BK_BND,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic signed [DIST_W-1:0] min_dist;
    logic signed [DIST_W-1:0] max_dist;
    logic [BSIZE_W-1:0]       bin_size;  // never zero
  } cfg_t;

  typedef struct packed {
    op_e         operation;
    logic [7:0]  end_count;
    logic [7:0]  hits_one;
    logic [7:0]  hits_two;
    logic [15:0] contig_one;
    logic [15:0] contig_two;
    logic        strand_one;
    logic        strand_two;
    logic [31:0] pos_one;
    logic [31:0] pos_two;
    logic [IDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    status_e             status;
    logic [DIST_W-1:0]   diff;
    logic [IDX_W-1:0]    index;
  } job_t;

  typedef struct packed {
    status_e                  status;
    logic [IDX_W-1:0]         bin_index;
    logic [CNT_W-1:0]         bin_count;
    logic signed [DIST_W-1:0] bin_low;
    logic signed [DIST_W-1:0] bin_high;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

  function automatic logic signed [DIST_W-1:0] sat32(input logic signed [BND_W-1:0] v);
    logic signed [BND_W-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[DIST_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/paired_end_distance_histogram_top.sv
// insert size histogram over paired-end alignment records
// s_axis carries one request per record: tuser selects insert or bin readout,
// tdata holds both ends' hit counts, contigs, strands, positions and the
// readout bin. m_axis returns exactly one result per request: tuser is the
// status, tdata the bin index, its count and its lower and upper bound.
// the apb port holds min distance, max distance and bin size; write it only
// while no request is outstanding.
// a two-entry queue sits between the classifier and the bin engine, so the
// input keeps accepting while the engine works or the output is stalled.
// a counted pair passes the one-bit-per-cycle bin divider, the counter read,
// the counter update, the bound step and the output stage; a readout skips
// the divider and a rejected record goes straight to the output stage. the
// engine takes one request at a time; a stalled output holds its result and
// the engine waits, then the queue fills and s_axis_tready drops.
// after reset the engine zeroes all 4096 counters, one per cycle, and holds
// s_axis_tready low while it does so; configuration writes still work.
// counters saturate at all ones.
`default_nettype none

module paired_end_distance_histogram_top (
  input  var logic                                   clk_i,
  input  var logic                                   rst_ni,
  input  var logic                                   s_axis_tvalid,
  output logic                                       s_axis_tready,
  // end_count, hits_one, hits_two, contig_one, contig_two, strand_one,
  // strand_two, pos_one, pos_two, read_index, zero pad
  input  var logic [pedh_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  // operation
  input  var logic [pedh_pkg::IN_TUSER_W-1:0]        s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  var logic                                   m_axis_tready,
  // bin_index, bin_count, bin_low, bin_high, zero pad
  output logic [pedh_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
  // status
  output logic [pedh_pkg::OUT_TUSER_W-1:0]           m_axis_tuser,
  input  var logic                                   psel,
  input  var logic                                   penable,
  input  var logic                                   pwrite,
  input  var logic [pedh_pkg::APB_AW-1:0]            paddr,
  input  var logic [31:0]                            pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready
);

`include "paired_end_distance_histogram_top_defines.svh"

  logic signed [pedh_pkg::DIST_W-1:0] min_q;
  logic signed [pedh_pkg::DIST_W-1:0] max_q;
  logic [pedh_pkg::BSIZE_W-1:0]       bs_q;
  logic                               reg_wr;
  pedh_pkg::reg_e                     reg_sel;

  pedh_pkg::cfg_t       cfg;
  pedh_pkg::item_t      item;
  pedh_pkg::job_t       push_job;
  pedh_pkg::job_t       head_job;
  logic                 push;
  logic                 pop;
  logic                 fifo_full;
  logic                 fifo_empty;
  pedh_pkg::result_t    out_res;
  pedh_pkg::back_stat_t back_stat;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = pedh_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= pedh_pkg::DIST_W'(1000);
      bs_q  <= pedh_pkg::BSIZE_W'(1);
    end else if (reg_wr) begin
      case (reg_sel)
        pedh_pkg::REG_MIN_DIST: min_q <= $signed(pwdata);
        pedh_pkg::REG_MAX_DIST: max_q <= $signed(pwdata);
        pedh_pkg::REG_BIN_SIZE: bs_q  <= pwdata[pedh_pkg::BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pedh_pkg::REG_MIN_DIST: prdata = min_q;
      pedh_pkg::REG_MAX_DIST: prdata = max_q;
      pedh_pkg::REG_BIN_SIZE: prdata = {1'b0, bs_q};
      default:                prdata = '0;
    endcase
  end

  // a zero bin size counts as one
  assign cfg.min_dist = min_q;
  assign cfg.max_dist = max_q;
  assign cfg.bin_size = (bs_q == '0) ? pedh_pkg::BSIZE_W'(1) : bs_q;

  assign item.operation  = pedh_pkg::op_e'(s_axis_tuser[0]);
  assign item.end_count  = s_axis_tdata[7:0];
  assign item.hits_one   = s_axis_tdata[15:8];
  assign item.hits_two   = s_axis_tdata[23:16];
  assign item.contig_one = s_axis_tdata[39:24];
  assign item.contig_two = s_axis_tdata[55:40];
  assign item.strand_one = s_axis_tdata[56];
  assign item.strand_two = s_axis_tdata[57];
  assign item.pos_one    = s_axis_tdata[89:58];
  assign item.pos_two    = s_axis_tdata[121:90];
  assign item.read_index = s_axis_tdata[133:122];

  pedh_front u_front (
    .item_i  (item),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .cfg_i   (cfg),
    .full_i  (fifo_full),
    .hold_i  (back_stat.clearing),
    .push_o  (push),
    .job_o   (push_job)
  );

  pedh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  pedh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_i       (head_job),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_res),
    .stat_o      (back_stat)
  );

  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {4'b0, out_res.bin_high, out_res.bin_low, out_res.bin_count,
                         out_res.bin_index};

  `PEDH_ASSERT_IMPL(a_reject_zero, m_axis_tvalid && (m_axis_tuser == pedh_pkg::ST_NOT_PAIRED || m_axis_tuser == pedh_pkg::ST_NOT_UNIQUE || m_axis_tuser == pedh_pkg::ST_MISMATCH || m_axis_tuser == pedh_pkg::ST_OUT_OF_RANGE), m_axis_tdata == '0, "rejected record carries bin data")
  `PEDH_ASSERT_IMPL(a_counted_bin, m_axis_tvalid && m_axis_tuser == pedh_pkg::ST_COUNTED, (out_res.bin_low <= out_res.bin_high) && (out_res.bin_count != '0), "counted pair with bad bounds or zero count")
  `PEDH_ASSERT_NEXT(a_request_kept, s_axis_tvalid && s_axis_tready, !fifo_empty || back_stat.busy, "accepted request lost between classifier and engine")

endmodule

`default_nettype wire

// File: rtl/core/pedh_front.sv
`default_nettype none

module pedh_front (
  input  var pedh_pkg::item_t item_i,
  input  var logic            valid_i,
  output logic                ready_o,
  input  var pedh_pkg::cfg_t  cfg_i,
  input  var logic            full_i,
  input  var logic            hold_i,
  output logic                push_o,
  output pedh_pkg::job_t      job_o
);

  logic [pedh_pkg::DIST_W-1:0]        pos_gap;
  logic signed [pedh_pkg::DIST_W-1:0] dist_s;
  logic [pedh_pkg::DIST_W-1:0]        diff;
  logic [pedh_pkg::SPAN_W-1:0]        span;
  logic                               in_range;
  logic                               beyond_store;

  assign pos_gap = item_i.pos_two - item_i.pos_one;
  assign dist_s  = $signed(pos_gap);
  assign diff    = pos_gap - cfg_i.min_dist;

  // distance covered by all bins together
  assign span = pedh_pkg::SPAN_W'(cfg_i.bin_size) * pedh_pkg::SPAN_W'(pedh_pkg::NUM_BINS);

  assign in_range     = (dist_s >= cfg_i.min_dist) && (dist_s <= cfg_i.max_dist);
  assign beyond_store = {{(pedh_pkg::SPAN_W-pedh_pkg::DIST_W){1'b0}}, diff} >= span;

  always_comb begin
    job_o.status = pedh_pkg::ST_COUNTED;
    job_o.diff   = diff;
    job_o.index  = item_i.read_index;
    if (item_i.operation == pedh_pkg::OP_READOUT) begin
      job_o.status = pedh_pkg::ST_READOUT;
    end else if (item_i.end_count != pedh_pkg::PAIR_ENDS) begin
      job_o.status = pedh_pkg::ST_NOT_PAIRED;
    end else if (item_i.hits_one != pedh_pkg::UNIQUE_HITS ||
                 item_i.hits_two != pedh_pkg::UNIQUE_HITS) begin
      job_o.status = pedh_pkg::ST_NOT_UNIQUE;
    end else if (item_i.contig_one != item_i.contig_two ||
                 item_i.strand_one != item_i.strand_two) begin
      job_o.status = pedh_pkg::ST_MISMATCH;
    end else if (!in_range || beyond_store) begin
      job_o.status = pedh_pkg::ST_OUT_OF_RANGE;
    end
  end

  assign ready_o = !full_i && !hold_i;
  assign push_o  = valid_i && ready_o;

endmodule

`default_nettype wire

// File: rtl/core/pedh_fifo.sv
`default_nettype none

module pedh_fifo (
  input  var logic           clk_i,
  input  var logic           rst_ni,
  input  var logic           push_i,
  input  var pedh_pkg::job_t job_i,
  input  var logic           pop_i,
  output pedh_pkg::job_t     job_o,
  output logic               full_o,
  output logic               empty_o
);

  pedh_pkg::job_t                 slot_q [pedh_pkg::FIFO_DEPTH];
  logic [pedh_pkg::FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [pedh_pkg::FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [pedh_pkg::FIFO_AW:0]     fill_q, fill_d;

  assign full_o  = fill_q == (pedh_pkg::FIFO_AW+1)'(pedh_pkg::FIFO_DEPTH);
  assign empty_o = fill_q == '0;
  assign job_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pedh_back.sv
`default_nettype none

module pedh_back (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var pedh_pkg::cfg_t      cfg_i,
  input  var pedh_pkg::job_t      job_i,
  input  var logic                empty_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  var logic                out_ready_i,
  output pedh_pkg::result_t       result_o,
  output pedh_pkg::back_stat_t    stat_o
);

  localparam logic signed [pedh_pkg::BND_W-1:0] ONE_B = pedh_pkg::BND_W'(1);

  pedh_pkg::back_state_e state_q, state_d;

  logic [pedh_pkg::CNT_W-1:0] bin_mem [pedh_pkg::NUM_BINS];
  logic                       mem_we;
  logic [pedh_pkg::BIN_AW-1:0] mem_wa;
  logic [pedh_pkg::CNT_W-1:0] mem_wd;
  logic [pedh_pkg::CNT_W-1:0] rd_q;

  logic [pedh_pkg::BIN_AW-1:0] clr_q, clr_d;
  pedh_pkg::job_t              job_q, job_d;
  logic [pedh_pkg::DIST_W-1:0] rem_q, rem_d;
  logic [pedh_pkg::SPAN_W-1:0] ds_q, ds_d;
  logic [pedh_pkg::IDX_W-1:0]  quo_q, quo_d;
  logic [pedh_pkg::STEP_W-1:0] step_q, step_d;
  logic [pedh_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [pedh_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [pedh_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic signed [pedh_pkg::BND_W-1:0] lo_q, lo_d;
  pedh_pkg::result_t           res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  pedh_pkg::result_t           out_q, out_d;

  logic                              ge;
  logic [pedh_pkg::PROD_W-1:0]       prod_c;
  logic [pedh_pkg::CNT_W-1:0]        inc;
  logic                              idx_ok;
  logic signed [pedh_pkg::BND_W-1:0] hi;
  logic signed [pedh_pkg::BND_W-1:0] hi_cap;
  logic signed [pedh_pkg::BND_W-1:0] max_ext;
  logic signed [pedh_pkg::BND_W-1:0] bs_ext;

  // one quotient bit per cycle, restoring
  assign ge     = {{(pedh_pkg::SPAN_W-pedh_pkg::DIST_W){1'b0}}, rem_q} >= ds_q;
  assign prod_c = idx_q * cfg_i.bin_size;
  assign inc    = (rd_q == '1) ? rd_q : rd_q + 1'b1;
  assign idx_ok = {1'b0, idx_q} < (pedh_pkg::IDX_W+1)'(pedh_pkg::NUM_BINS);

  assign max_ext = $signed({{(pedh_pkg::BND_W-pedh_pkg::DIST_W){cfg_i.max_dist[31]}},
                            cfg_i.max_dist});
  assign bs_ext  = $signed({{(pedh_pkg::BND_W-pedh_pkg::BSIZE_W){1'b0}}, cfg_i.bin_size});
  assign hi      = lo_q + bs_ext - ONE_B;
  assign hi_cap  = (hi > max_ext) ? max_ext : hi;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    job_d       = job_q;
    rem_d       = rem_q;
    ds_d        = ds_q;
    quo_d       = quo_q;
    step_d      = step_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = idx_q[pedh_pkg::BIN_AW-1:0];
    mem_wd      = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pedh_pkg::BK_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == pedh_pkg::BIN_AW'(pedh_pkg::NUM_BINS - 1)) begin
          state_d = pedh_pkg::BK_IDLE;
        end
      end
      pedh_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          case (job_i.status)
            pedh_pkg::ST_COUNTED: begin
              rem_d   = job_i.diff;
              ds_d    = pedh_pkg::SPAN_W'(cfg_i.bin_size) << (pedh_pkg::IDX_W - 1);
              quo_d   = '0;
              step_d  = pedh_pkg::STEP_W'(pedh_pkg::IDX_W - 1);
              state_d = pedh_pkg::BK_DIV;
            end
            pedh_pkg::ST_READOUT: begin
              idx_d   = job_i.index;
              state_d = pedh_pkg::BK_READ;
            end
            default: begin
              res_d        = '0;
              res_d.status = job_i.status;
              state_d      = pedh_pkg::BK_OUT;
            end
          endcase
        end
      end
      pedh_pkg::BK_DIV: begin
        if (ge) begin
          rem_d = rem_q - ds_q[pedh_pkg::DIST_W-1:0];
        end
        quo_d  = {quo_q[pedh_pkg::IDX_W-2:0], ge};
        ds_d   = ds_q >> 1;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          idx_d   = {quo_q[pedh_pkg::IDX_W-2:0], ge};
          state_d = pedh_pkg::BK_READ;
        end
      end
      pedh_pkg::BK_READ: begin
        // counter read is in flight, multiplier starts on the bin base
        prod_d  = prod_c;
        state_d = pedh_pkg::BK_UPD;
      end
      pedh_pkg::BK_UPD: begin
        if (job_q.status == pedh_pkg::ST_COUNTED) begin
          mem_we = 1'b1;
          mem_wd = inc;
          cnt_d  = inc;
        end else begin
          cnt_d = idx_ok ? rd_q : '0;
        end
        lo_d = $signed({{(pedh_pkg::BND_W-pedh_pkg::DIST_W){cfg_i.min_dist[31]}},
                        cfg_i.min_dist})
             + $signed({{(pedh_pkg::BND_W-pedh_pkg::PROD_W){1'b0}}, prod_q});
        state_d = pedh_pkg::BK_BND;
      end
      pedh_pkg::BK_BND: begin
        res_d.status    = job_q.status;
        res_d.bin_index = idx_q;
        res_d.bin_count = cnt_q;
        res_d.bin_low   = pedh_pkg::sat32(lo_q);
        res_d.bin_high  = pedh_pkg::sat32(hi_cap);
        state_d         = pedh_pkg::BK_OUT;
      end
      pedh_pkg::BK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = pedh_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = pedh_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pedh_pkg::BK_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    rem_q  <= rem_d;
    ds_q   <= ds_d;
    quo_q  <= quo_d;
    idx_q  <= idx_d;
    prod_q <= prod_d;
    cnt_q  <= cnt_d;
    lo_q   <= lo_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem[mem_wa] <= mem_wd;
    end
    rd_q <= bin_mem[idx_q[pedh_pkg::BIN_AW-1:0]];
  end

  assign out_valid_o     = out_valid_q;
  assign result_o        = out_q;
  assign stat_o.clearing = state_q == pedh_pkg::BK_CLEAR;
  assign stat_o.busy     = state_q != pedh_pkg::BK_IDLE;

endmodule

`default_nettype wire

// File: dv/insert_size_checker.sv
module insert_size_checker
  import pedh_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [31:0]            pwdata,
  input  logic                   pready,
  output int                     errors_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint I32_MAX = 64'sh7FFF_FFFF;
  localparam longint I32_MIN = -64'sh8000_0000;

  logic signed [DIST_W-1:0] min_q;
  logic signed [DIST_W-1:0] max_q;
  logic [BSIZE_W-1:0]       size_q;
  logic [CNT_W-1:0]         hist_q [NUM_BINS];
  result_t                  expected_q [$];
  int                       fail_count = 0;
  int                       pending = 0;

  assign errors_o  = fail_count;
  assign pending_o = pending;

  function automatic longint clamp32(longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  function automatic void fill_bounds(inout result_t r, input longint idx, input longint bs);
    longint lo;
    longint hi;
    lo = longint'(min_q) + idx * bs;
    hi = lo + bs - 1;
    if (hi > longint'(max_q)) hi = longint'(max_q);
    lo = clamp32(lo);
    hi = clamp32(hi);
    r.bin_low  = lo[DIST_W-1:0];
    r.bin_high = hi[DIST_W-1:0];
  endfunction

  // next histogram result for one request; a counted pair also updates its bin counter
  function automatic result_t predict_bin(item_t it);
    result_t     r;
    logic [31:0] diff;
    longint      d;
    longint      bs;
    longint      idx;
    r  = '0;
    bs = (size_q == '0) ? 64'sd1 : longint'(size_q);
    if (it.operation == OP_READOUT) begin
      r.status    = ST_READOUT;
      r.bin_index = it.read_index;
      r.bin_count = (int'(it.read_index) < NUM_BINS) ? hist_q[it.read_index] : '0;
      fill_bounds(r, longint'(it.read_index), bs);
      return r;
    end
    if (it.end_count != PAIR_ENDS) begin
      r.status = ST_NOT_PAIRED;
      return r;
    end
    if (it.hits_one != UNIQUE_HITS || it.hits_two != UNIQUE_HITS) begin
      r.status = ST_NOT_UNIQUE;
      return r;
    end
    if (it.contig_one != it.contig_two || it.strand_one != it.strand_two) begin
      r.status = ST_MISMATCH;
      return r;
    end
    diff = it.pos_two - it.pos_one;
    d    = longint'($signed(diff));
    if (d < longint'(min_q) || d > longint'(max_q)) begin
      r.status = ST_OUT_OF_RANGE;
      return r;
    end
    idx = (d - longint'(min_q)) / bs;
    if (idx >= NUM_BINS) begin
      r.status = ST_OUT_OF_RANGE;
      return r;
    end
    if (hist_q[idx] != '1) hist_q[idx] = hist_q[idx] + 1;
    r.status    = ST_COUNTED;
    r.bin_index = idx[IDX_W-1:0];
    r.bin_count = hist_q[idx];
    fill_bounds(r, idx, bs);
    return r;
  endfunction

  function automatic void note_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t      it;
    result_t    got;
    result_t    want;
    logic [1:0] in_pad;
    logic [3:0] out_pad;
    if (!rst_ni) begin
      min_q  = 32'sd0;
      max_q  = 32'sd1000;
      size_q = 31'd1;
      foreach (hist_q[i]) hist_q[i] = '0;
      expected_q.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[3:2]))
          REG_MIN_DIST: min_q = pwdata;
          REG_MAX_DIST: max_q = pwdata;
          REG_BIN_SIZE: size_q = pwdata[BSIZE_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        {out_pad, got.bin_high, got.bin_low, got.bin_count, got.bin_index} = m_axis_tdata;
        got.status = status_e'(m_axis_tuser);
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, expected none actual %h %h", $time,
                   m_axis_tuser, m_axis_tdata);
        end else begin
          want = expected_q.pop_front();
          note_field("status", 32'(want.status), 32'(got.status));
          note_field("bin_index", 32'(want.bin_index), 32'(got.bin_index));
          note_field("bin_count", want.bin_count, got.bin_count);
          note_field("bin_low", want.bin_low, got.bin_low);
          note_field("bin_high", want.bin_high, got.bin_high);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        {in_pad, it.read_index, it.pos_two, it.pos_one, it.strand_two, it.strand_one,
         it.contig_two, it.contig_one, it.hits_two, it.hits_one, it.end_count} = s_axis_tdata;
        it.operation = op_e'(s_axis_tuser[0]);
        expected_q.push_back(predict_bin(it));
      end
      pending = expected_q.size();
    end
  end

endmodule

// File: dv/tb.sv
module tb;
  import pedh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  int                     errors;
  int                     pending;

  bit     idle_en = 1'b1;
  bit     hold_off = 1'b0;
  longint cur_min = 0;
  longint cur_max = 1000;
  longint cur_size = 1;

  longint ph_min [8] = '{0, 0, -64'sd2147483648, -500, 100, 64'sd2147479552, 0, -2000};
  longint ph_max [8] = '{1000, 100000, 64'sd2147483647, 3000, 50, 64'sd2147483647, 0, 2000};
  longint ph_size [8] = '{1, 1, 64'sd2147483647, 0, 3, 16, 1, 7};
  int     ph_items [8] = '{280, 250, 250, 300, 120, 200, 200, 330};

  always #5 clk_i = ~clk_i;

  paired_end_distance_histogram_top i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  insert_size_checker i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    #8ms;
    $display("tb: FAIL");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (499) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_e r, longint v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v[31:0];
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(longint lo, longint hi, longint bs);
    write_reg(REG_MIN_DIST, lo);
    write_reg(REG_MAX_DIST, hi);
    write_reg(REG_BIN_SIZE, bs);
    cur_min  = lo;
    cur_max  = hi;
    cur_size = (bs == 0) ? 1 : bs;
  endtask

  task automatic push_request(item_t it);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.operation;
    s_axis_tdata  <= {2'b00, it.read_index, it.pos_two, it.pos_one, it.strand_two,
                      it.strand_one, it.contig_two, it.contig_one, it.hits_two,
                      it.hits_one, it.end_count};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // called at a falling edge right after the last accepted request
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk_i);
  endtask

  // well-formed pair with the given distance, random content elsewhere
  function automatic item_t pair_at(longint p1, longint dist_in);
    item_t  it;
    longint p2;
    p2 = p1 + dist_in;
    it.operation  = OP_INSERT;
    it.end_count  = PAIR_ENDS;
    it.hits_one   = UNIQUE_HITS;
    it.hits_two   = UNIQUE_HITS;
    it.contig_one = 16'($urandom);
    it.contig_two = it.contig_one;
    it.strand_one = 1'($urandom);
    it.strand_two = it.strand_one;
    it.pos_one    = p1[31:0];
    it.pos_two    = p2[31:0];
    it.read_index = 12'($urandom);
    return it;
  endfunction

  function automatic item_t readout_of(logic [IDX_W-1:0] idx);
    item_t it;
    it = pair_at($urandom, $urandom);
    it.end_count  = 8'($urandom);
    it.operation  = OP_READOUT;
    it.read_index = idx;
    return it;
  endfunction

  function automatic item_t random_request();
    item_t  it;
    longint span;
    longint lim;
    longint d;
    int     pick;
    pick = $urandom_range(0, 99);
    span = cur_max - cur_min;
    lim  = (span < cur_size * 4200) ? span : cur_size * 4200;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if (lim < 0) d = longint'($signed($urandom));
        else d = cur_min + longint'(({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF) % (lim + 1));
      end
      6, 7: begin
        case ($urandom_range(0, 4))
          0: d = cur_min;
          1: d = cur_max;
          2: d = cur_min - 1;
          3: d = cur_max + 1;
          default: d = cur_min + cur_size * $urandom_range(4090, 4100);
        endcase
      end
      default: d = longint'($signed($urandom));
    endcase
    it = pair_at($urandom, d);
    if (pick < 15) begin
      it = readout_of($urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 63)));
    end else if (pick < 30) begin
      // broken or noisy record
      case ($urandom_range(0, 5))
        0: it.end_count = 8'($urandom);
        1: it.hits_one = 8'($urandom);
        2: it.hits_two = 8'($urandom);
        3: it.contig_two = it.contig_one ^ 16'($urandom_range(1, 65535));
        4: it.strand_two = ~it.strand_one;
        default: begin
          it.end_count  = 8'($urandom);
          it.hits_one   = 8'($urandom);
          it.hits_two   = 8'($urandom);
          it.contig_two = 16'($urandom);
          it.strand_two = 1'($urandom);
        end
      endcase
    end
    return it;
  endfunction

  initial begin
    item_t it;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed requests under the reset configuration
    push_request(readout_of(12'd0));
    push_request(pair_at(100, 0));
    push_request(pair_at($urandom, 1000));
    push_request(pair_at($urandom, 1001));
    push_request(pair_at($urandom, -1));
    push_request(pair_at(64'hFFFF_FFFF, 5));
    it = pair_at(7, 3); it.end_count = 8'd0;   push_request(it);
    it = pair_at(7, 3); it.end_count = 8'd255; push_request(it);
    it = pair_at(7, 3); it.end_count = 8'd1;   push_request(it);
    it = pair_at(7, 3); it.end_count = 8'd3; it.hits_one = 8'd0; push_request(it);
    it = pair_at(7, 3); it.hits_one = 8'd0;    push_request(it);
    it = pair_at(7, 3); it.hits_two = 8'd255;  push_request(it);
    it = pair_at(7, 3); it.hits_one = 8'd2; it.contig_two = ~it.contig_one; push_request(it);
    it = pair_at(7, 3); it.contig_two = ~it.contig_one; push_request(it);
    it = pair_at(7, 3); it.strand_two = ~it.strand_one; push_request(it);
    it = pair_at(7, 5000); it.strand_two = ~it.strand_one; push_request(it);
    push_request(pair_at(0, 64'hFFFF_FFFF));
    push_request(pair_at(64'h8000_0000, -1));
    push_request(pair_at(64'h7FFF_FFFF, 1));
    push_request(readout_of(12'hFFF));
    push_request(readout_of(12'd1000));
    push_request(readout_of(12'd0));

    ph_min[6]  = longint'($urandom_range(0, 200000)) - 100000;
    ph_max[6]  = ph_min[6] + $urandom_range(0, 50000);
    ph_size[6] = $urandom_range(0, 40);

    for (int p = 0; p < 8; p++) begin
      settle();
      if (p > 0) apply_config(ph_min[p], ph_max[p], ph_size[p]);
      if (p == 2) hold_off = 1'b1;
      if (p == 7) idle_en = 1'b0;
      repeat (ph_items[p]) push_request(random_request());
    end

    settle();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pedh_pkg.sv
rtl/core/pedh_front.sv
rtl/core/pedh_fifo.sv
rtl/core/pedh_back.sv
rtl/core/paired_end_distance_histogram_top.sv
dv/insert_size_checker.sv
dv/tb.sv
